### sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro checks on the rising clock edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clock, resetn, cond) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clock, resetn, cond)
`define ASSERT_IMPLY(label, clock, resetn, ante, cons)
`define ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

### sv/tlvd_pkg.sv
`timescale 1ns / 1ps

package tlvd_pkg;

    // Length byte that announces a multi-byte long length.
    localparam logic [7:0] LEN_ESCAPE = 8'hFF;

    // Default number of bytes in a long length field.
    localparam int LONG_LENGTH_BYTES = 4;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic CFG_IDX_LENGTH_BIG_ENDIAN = 1'b0;

    // Parser phases.
    typedef enum logic [1:0] {
        PH_TAG   = 2'd0,
        PH_LEN   = 2'd1,
        PH_LONG  = 2'd2,
        PH_VALUE = 2'd3
    } phase_t;

    // One input byte after classification.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_escape;
        logic       is_zero;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  element_tag;
        logic [7:0]  value_byte;
        logic        byte_valid;
        logic [31:0] value_offset;
        logic        element_end;
        logic        truncated;
        logic        buffer_end;
    } result_t;

endpackage

### sv/tlv_stream_deframer_top.sv
`timescale 1ns / 1ps
// Channel   | Handshake                          | Payload
// ----------+------------------------------------+-------------------------------------------
// input     | in_valid / in_ready                | data_byte, buffer_last
// output    | out_valid / out_ready              | element_tag, value_byte, byte_valid,
//           |                                    | value_offset, element_end, truncated,
//           |                                    | buffer_end
// config    | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// One byte per cycle sustained while the output is not stalled; a result reaches the output
// register from its byte through the two-entry queue and the parser step.
// Reset is asynchronous and active low; the parser restarts expecting a tag byte.
// A stalled output holds its result while the queue keeps taking up to two more bytes.
// The long length byte order register is read and written at byte address 0.

`include "assert_macros.svh"

module tlv_stream_deframer_top #(
    parameter int LongLengthBytes = tlvd_pkg::LONG_LENGTH_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        buffer_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  element_tag,
    output logic [7:0]  value_byte,
    output logic        byte_valid,
    output logic [31:0] value_offset,
    output logic        element_end,
    output logic        truncated,
    output logic        buffer_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               big_endian_reg;
    logic               big_endian_next;
    logic               cfg_write;
    logic               head_valid;
    tlvd_pkg::item_t    head;
    logic               pop;
    tlvd_pkg::result_t  result;

    // Configuration port: always ready, register index from the word address.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        big_endian_next = big_endian_reg;
        if (cfg_write && (paddr[2] == tlvd_pkg::CFG_IDX_LENGTH_BIG_ENDIAN))
        begin
            big_endian_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tlvd_pkg::CFG_IDX_LENGTH_BIG_ENDIAN)
        begin
            prdata = {31'd0, big_endian_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg <= 1'b0;
        end
        else
        begin
            big_endian_reg <= big_endian_next;
        end
    end

    // Front: classify bytes and queue them.
    tlvd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .buffer_last (buffer_last),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop)
    );

    // Back: parse queued bytes and hold the result.
    tlvd_back #(
        .LongLengthBytes (LongLengthBytes)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .big_endian (big_endian_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    // Unpack the result onto the output ports.
    assign element_tag  = result.element_tag;
    assign value_byte   = result.value_byte;
    assign byte_valid   = result.byte_valid;
    assign value_offset = result.value_offset;
    assign element_end  = result.element_end;
    assign truncated    = result.truncated;
    assign buffer_end   = result.buffer_end;

    // A full queue always presents a head byte to the parser.
    `ASSERT_IMPLY(a_full_has_head, clk, rst_n, !in_ready, head_valid)

    // A truncated result never carries a value byte or an element end.
    `ASSERT_IMPLY(a_trunc_empty, clk, rst_n, out_valid && truncated, !byte_valid && !element_end)

    // A result without a value byte reports a zero byte and offset.
    `ASSERT_IMPLY(a_novalue_zero, clk, rst_n, out_valid && !byte_valid, !(|{value_byte, value_offset}))

    // A stalled result stays valid until it is taken.
    `ASSERT_NEXT(a_stall_no_pop, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

### sv/tlvd_front.sv
`timescale 1ns / 1ps

module tlvd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                buffer_last,
    output logic                head_valid,
    output tlvd_pkg::item_t     head,
    input  logic                pop
);

    localparam int PTR_W = (tlvd_pkg::QUEUE_DEPTH > 1) ? $clog2(tlvd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tlvd_pkg::QUEUE_DEPTH + 1);

    tlvd_pkg::item_t    slot_reg [tlvd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    tlvd_pkg::item_t    item_in;
    logic               push;

    // Classify the incoming byte so the parser needs no wide compare.
    always_comb
    begin
        item_in.data      = data_byte;
        item_in.last      = buffer_last;
        item_in.is_escape = (data_byte == tlvd_pkg::LEN_ESCAPE);
        item_in.is_zero   = (data_byte == 8'd0);
    end

    assign in_ready   = (count_reg != CNT_W'(tlvd_pkg::QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tlvd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tlvd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; a slot is written on each accepted transfer.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### sv/tlvd_back.sv
`timescale 1ns / 1ps

module tlvd_back #(
    parameter int LongLengthBytes = tlvd_pkg::LONG_LENGTH_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                big_endian,
    input  logic                head_valid,
    input  tlvd_pkg::item_t     head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output tlvd_pkg::result_t   result
);

    // The counter also indexes the first four length bytes, so keep at least three bits.
    localparam int CNT_RAW = $clog2(LongLengthBytes + 1);
    localparam int CNT_W   = (CNT_RAW < 3) ? 3 : CNT_RAW;

    tlvd_pkg::phase_t   phase_reg;
    tlvd_pkg::phase_t   phase_next;
    logic [7:0]         tag_reg;
    logic [7:0]         tag_next;
    logic [31:0]        rem_reg;
    logic [31:0]        rem_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [31:0]        pos_reg;
    logic [31:0]        pos_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               skip_reg;
    logic               skip_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    tlvd_pkg::result_t  res_reg;
    tlvd_pkg::result_t  res_next;
    logic               emit;

    // Take the next byte whenever the output register is free or being drained.
    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    // Per-byte parser step.
    always_comb
    begin
        logic [31:0]      lrem;
        logic             lovf;
        logic [CNT_W-1:0] lcnt;

        phase_next = phase_reg;
        tag_next   = tag_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        skip_next  = skip_reg;
        emit       = 1'b0;
        res_next   = '0;
        res_next.element_tag = tag_reg;
        lrem       = rem_reg;
        lovf       = ovf_reg;
        lcnt       = cnt_reg + 1'b1;

        if (pop)
        begin
            if (skip_reg)
            begin
                // Drop the rest of a buffer after an oversized long length.
                if (head.last)
                begin
                    skip_next = 1'b0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    tlvd_pkg::PH_TAG:
                    begin
                        tag_next = head.data;
                        res_next.element_tag = head.data;
                        if (head.last)
                        begin
                            emit = 1'b1;
                            res_next.truncated  = 1'b1;
                            res_next.buffer_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = tlvd_pkg::PH_LEN;
                        end
                    end
                    tlvd_pkg::PH_LEN:
                    begin
                        pos_next = '0;
                        if (head.is_escape)
                        begin
                            rem_next = '0;
                            cnt_next = '0;
                            ovf_next = 1'b0;
                            if (head.last)
                            begin
                                emit = 1'b1;
                                res_next.truncated  = 1'b1;
                                res_next.buffer_end = 1'b1;
                            end
                            else
                            begin
                                phase_next = tlvd_pkg::PH_LONG;
                            end
                        end
                        else if (head.is_zero)
                        begin
                            // Empty element: one end result with no value byte.
                            emit = 1'b1;
                            res_next.element_end = 1'b1;
                            res_next.buffer_end  = head.last;
                            phase_next = tlvd_pkg::PH_TAG;
                        end
                        else
                        begin
                            rem_next = {24'd0, head.data};
                            if (head.last)
                            begin
                                emit = 1'b1;
                                res_next.truncated  = 1'b1;
                                res_next.buffer_end = 1'b1;
                            end
                            else
                            begin
                                phase_next = tlvd_pkg::PH_VALUE;
                            end
                        end
                    end
                    tlvd_pkg::PH_LONG:
                    begin
                        // Accumulate one long length byte and flag values above 32 bits.
                        if (big_endian)
                        begin
                            if (rem_reg[31:24] != 8'd0)
                            begin
                                lovf = 1'b1;
                            end
                            lrem = {rem_reg[23:0], head.data};
                        end
                        else if (cnt_reg < CNT_W'(4))
                        begin
                            unique case (cnt_reg[1:0])
                                2'd0:    lrem = rem_reg | {24'd0, head.data};
                                2'd1:    lrem = rem_reg | {16'd0, head.data, 8'd0};
                                2'd2:    lrem = rem_reg | {8'd0, head.data, 16'd0};
                                default: lrem = rem_reg | {head.data, 24'd0};
                            endcase
                        end
                        else if (!head.is_zero)
                        begin
                            lovf = 1'b1;
                        end
                        rem_next = lrem;
                        ovf_next = lovf;
                        cnt_next = lcnt;
                        if (lcnt >= CNT_W'(LongLengthBytes))
                        begin
                            phase_next = tlvd_pkg::PH_VALUE;
                            if (lovf)
                            begin
                                emit = 1'b1;
                                res_next.truncated  = 1'b1;
                                res_next.buffer_end = head.last;
                                phase_next = tlvd_pkg::PH_TAG;
                                skip_next  = !head.last;
                            end
                            else if (lrem == 32'd0)
                            begin
                                emit = 1'b1;
                                res_next.element_end = 1'b1;
                                res_next.buffer_end  = head.last;
                                phase_next = tlvd_pkg::PH_TAG;
                            end
                            else if (head.last)
                            begin
                                emit = 1'b1;
                                res_next.truncated  = 1'b1;
                                res_next.buffer_end = 1'b1;
                            end
                        end
                        else if (head.last)
                        begin
                            emit = 1'b1;
                            res_next.truncated  = 1'b1;
                            res_next.buffer_end = 1'b1;
                        end
                    end
                    tlvd_pkg::PH_VALUE:
                    begin
                        if (rem_reg <= 32'd1)
                        begin
                            // Final value byte of the element.
                            emit = 1'b1;
                            res_next.value_byte   = head.data;
                            res_next.byte_valid   = 1'b1;
                            res_next.value_offset = pos_reg;
                            res_next.element_end  = 1'b1;
                            res_next.buffer_end   = head.last;
                            rem_next   = '0;
                            phase_next = tlvd_pkg::PH_TAG;
                        end
                        else if (head.last)
                        begin
                            emit = 1'b1;
                            res_next.truncated  = 1'b1;
                            res_next.buffer_end = 1'b1;
                        end
                        else
                        begin
                            emit = 1'b1;
                            res_next.value_byte   = head.data;
                            res_next.byte_valid   = 1'b1;
                            res_next.value_offset = pos_reg;
                            rem_next = rem_reg - 32'd1;
                            pos_next = pos_reg + 32'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = tlvd_pkg::PH_TAG;
                    end
                endcase
            end

            // Every final byte of a buffer starts the next buffer at a tag.
            if (head.last)
            begin
                phase_next = tlvd_pkg::PH_TAG;
            end
        end
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Parser and output control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tlvd_pkg::PH_TAG;
            tag_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tag_reg       <= tag_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload is loaded only when a result is produced.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### tb/sv/tlv_stream_deframer_top_test.sv
`timescale 1ns / 1ps

module tlv_stream_deframer_top_test;

    // Register addressing and run timing.
    localparam int REG_STRIDE    = 4;
    localparam int CFG_IDX_UNUSED = 1;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_BYTES   = 165;
    localparam int HOLD_CYCLES   = 80;
    localparam int REPORT_LIMIT  = 10;

    // Tracks the parser state and holds the results still owed by the block.
    class tlv_element_tracker;
        tlvd_pkg::phase_t  phase;
        logic [7:0]        tag;
        logic [31:0]       remaining;
        int                len_count;
        logic [31:0]       position;
        bit                len_overflow;
        bit                skip_rest;
        bit                big_endian;
        tlvd_pkg::result_t pending_results[$];
        int                fail_count;

        function new();
            phase        = tlvd_pkg::PH_TAG;
            tag          = '0;
            remaining    = '0;
            len_count    = 0;
            position     = '0;
            len_overflow = 0;
            skip_rest    = 0;
            big_endian   = 0;
            fail_count   = 0;
        endfunction

        function string show(tlvd_pkg::result_t r);
            return $sformatf("tag=%02h byte=%02h bv=%0b off=%0d end=%0b trunc=%0b bend=%0b",
                r.element_tag, r.value_byte, r.byte_valid, r.value_offset,
                r.element_end, r.truncated, r.buffer_end);
        endfunction

        function void note_failure(string detail);
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("MISMATCH at %0t: %s", $realtime, detail);
        endfunction

        function void write_register(int index, logic [31:0] value);
            if (index == tlvd_pkg::CFG_IDX_LENGTH_BIG_ENDIAN)
                big_endian = value[0];
        endfunction

        // Advance the parser by one accepted byte and queue any result it causes.
        function void take_byte(logic [7:0] b, logic last);
            tlvd_pkg::result_t r;
            bit                produce;
            r = '0;
            produce = 0;
            // After an oversized long length the rest of the buffer is dropped.
            if (skip_rest)
            begin
                if (last)
                begin
                    skip_rest = 0;
                    phase = tlvd_pkg::PH_TAG;
                end
                return;
            end
            case (phase)
                tlvd_pkg::PH_TAG:
                begin
                    tag = b;
                    if (last)
                    begin
                        produce = 1;
                        r.truncated = 1;
                    end
                    else
                    begin
                        phase = tlvd_pkg::PH_LEN;
                    end
                end
                tlvd_pkg::PH_LEN:
                begin
                    position = '0;
                    if (b == tlvd_pkg::LEN_ESCAPE)
                    begin
                        remaining = '0;
                        len_count = 0;
                        len_overflow = 0;
                        if (last)
                        begin
                            produce = 1;
                            r.truncated = 1;
                        end
                        else
                        begin
                            phase = tlvd_pkg::PH_LONG;
                        end
                    end
                    else if (b == 8'h00)
                    begin
                        produce = 1;
                        r.element_end = 1;
                        phase = tlvd_pkg::PH_TAG;
                    end
                    else
                    begin
                        remaining = 32'(b);
                        if (last)
                        begin
                            produce = 1;
                            r.truncated = 1;
                        end
                        else
                        begin
                            phase = tlvd_pkg::PH_VALUE;
                        end
                    end
                end
                tlvd_pkg::PH_LONG:
                begin
                    // Assemble the long length in the selected byte order.
                    if (big_endian)
                    begin
                        if (remaining[31:24] != 8'h00)
                            len_overflow = 1;
                        remaining = {remaining[23:0], b};
                    end
                    else if (len_count < $bits(remaining) / 8)
                    begin
                        remaining |= 32'(b) << (8 * len_count);
                    end
                    else if (b != 8'h00)
                    begin
                        len_overflow = 1;
                    end
                    len_count++;
                    if (len_count >= tlvd_pkg::LONG_LENGTH_BYTES)
                    begin
                        produce = 1;
                        if (len_overflow)
                        begin
                            r.truncated = 1;
                            skip_rest = !last;
                        end
                        else if (remaining == 0)
                        begin
                            r.element_end = 1;
                        end
                        else if (last)
                        begin
                            r.truncated = 1;
                        end
                        else
                        begin
                            produce = 0;
                        end
                        phase = produce ? tlvd_pkg::PH_TAG : tlvd_pkg::PH_VALUE;
                    end
                    else if (last)
                    begin
                        produce = 1;
                        r.truncated = 1;
                    end
                end
                default:
                begin
                    if (remaining <= 1)
                    begin
                        produce = 1;
                        r.byte_valid = 1;
                        r.value_byte = b;
                        r.value_offset = position;
                        r.element_end = 1;
                        remaining = '0;
                        phase = tlvd_pkg::PH_TAG;
                    end
                    else if (last)
                    begin
                        produce = 1;
                        r.truncated = 1;
                    end
                    else
                    begin
                        produce = 1;
                        r.byte_valid = 1;
                        r.value_byte = b;
                        r.value_offset = position;
                        remaining--;
                        position++;
                    end
                end
            endcase
            if (last)
                phase = tlvd_pkg::PH_TAG;
            if (produce)
            begin
                r.element_tag = tag;
                r.buffer_end = last;
                pending_results.push_back(r);
            end
        endfunction

        // Compare one output transfer with the oldest outstanding result.
        function void match_result(tlvd_pkg::result_t got);
            tlvd_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                note_failure({"unexpected result ", show(got)});
                return;
            end
            want = pending_results.pop_front();
            if (got.element_tag !== want.element_tag || got.value_byte !== want.value_byte ||
                got.byte_valid !== want.byte_valid || got.value_offset !== want.value_offset ||
                got.element_end !== want.element_end || got.truncated !== want.truncated ||
                got.buffer_end !== want.buffer_end)
                note_failure({"expected ", show(want), " got ", show(got)});
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        buffer_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  element_tag;
    logic [7:0]  value_byte;
    logic        byte_valid;
    logic [31:0] value_offset;
    logic        element_end;
    logic        truncated;
    logic        buffer_end;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tlv_element_tracker elements = new();
    logic [7:0]         buffer_bytes[$];
    int                 bytes_sent = 0;
    bit                 no_idle = 0;
    int                 hold_cycles = 0;

    tlv_stream_deframer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .buffer_last  (buffer_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .element_tag  (element_tag),
        .value_byte   (value_byte),
        .byte_valid   (byte_valid),
        .value_offset (value_offset),
        .element_end  (element_end),
        .truncated    (truncated),
        .buffer_end   (buffer_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Free-running clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watch both channels; a result is checked before the byte of the same edge is noted.
    always @(posedge clk)
    begin
        tlvd_pkg::result_t seen;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {element_tag, value_byte, byte_valid, value_offset,
                        element_end, truncated, buffer_end};
                elements.match_result(seen);
            end
            if (in_valid && in_ready)
                elements.take_byte(data_byte, buffer_last);
        end
    end

    // Output side: random stalls per transfer, plus one long hold-off on request.
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (gap != 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one byte and return at the falling edge after its transfer.
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        data_byte = b;
        buffer_last = last;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Stop sending and let every owed result arrive, then let the pipeline settle.
    task automatic wait_for_results();
        in_valid = 1'b0;
        while (elements.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Register write followed by a read back of the byte order register.
    task automatic set_length_order(int index, logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 3'(index * REG_STRIDE);
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        elements.write_register(index, value);
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'(tlvd_pkg::CFG_IDX_LENGTH_BIG_ENDIAN * REG_STRIDE);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[0] !== elements.big_endian)
            elements.note_failure($sformatf("byte order register read %0b, expected %0b",
                prdata[0], elements.big_endian));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Append one well-formed element with random tag, length form and content.
    function automatic void add_element();
        int kind;
        int len;
        int pos;
        kind = $urandom_range(0, 99);
        buffer_bytes.push_back(8'($urandom_range(0, 255)));
        if (kind < 25)
        begin
            buffer_bytes.push_back(8'h00);
            return;
        end
        if (kind < 75)
        begin
            len = (kind < 70) ? $urandom_range(1, 8) : $urandom_range(9, 254);
            buffer_bytes.push_back(8'(len));
        end
        else
        begin
            len = (kind < 80) ? 0 : (kind < 97) ? $urandom_range(1, 6) : $urandom_range(256, 300);
            buffer_bytes.push_back(tlvd_pkg::LEN_ESCAPE);
            for (int i = 0; i < tlvd_pkg::LONG_LENGTH_BYTES; i++)
            begin
                pos = elements.big_endian ? tlvd_pkg::LONG_LENGTH_BYTES - 1 - i : i;
                buffer_bytes.push_back(pos < 4 ? 8'(len >> (8 * pos)) : 8'h00);
            end
        end
        repeat (len) buffer_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Mostly complete buffers, some cut short inside an element, some raw noise.
    task automatic send_random_buffer();
        int kind;
        int cut;
        kind = $urandom_range(0, 99);
        buffer_bytes.delete();
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 12)) buffer_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 3)) add_element();
            if (kind < 20)
            begin
                cut = $urandom_range(0, buffer_bytes.size() - 2);
                buffer_bytes = buffer_bytes[0:cut];
            end
        end
        foreach (buffer_bytes[i])
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
    endtask

    // Reset, directed cases, then random phases with changing byte order and pacing.
    initial
    begin
        logic [8:0] directed[] = '{
            9'h000, 9'h000,
            9'h0FF, 9'h001, 9'h0AA,
            9'h05A, 9'h0FF, 9'h002, 9'h000, 9'h000, 9'h000, 9'h000, 9'h1FF,
            9'h111,
            9'h022, 9'h103,
            9'h033, 9'h0FE, 9'h07E, 9'h181,
            9'h044, 9'h1FF,
            9'h055, 9'h0FF, 9'h000, 9'h100
        };
        int phase_start;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty element, single byte, little endian long length, and buffers cut
        // at the tag, the length byte, the value, the escape and the long length.
        set_length_order(tlvd_pkg::CFG_IDX_LENGTH_BIG_ENDIAN, 32'd0);
        foreach (directed[i])
            send_byte(directed[i][7:0], directed[i][8]);

        for (int p = 0; p < 6; p++)
        begin
            wait_for_results();
            if (p == 3)
                set_length_order(CFG_IDX_UNUSED, $urandom);
            set_length_order(tlvd_pkg::CFG_IDX_LENGTH_BIG_ENDIAN,
                p == 3 ? 32'($urandom_range(0, 1)) : 32'(p % 2));
            no_idle = (p == 2);
            // Long output stall while input keeps coming, so the input backs up.
            if (p == 4)
                hold_cycles = HOLD_CYCLES;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_buffer();
        end
        no_idle = 0;
        wait_for_results();

        if (elements.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
